/* rtl/core/round_robin_lane_allocator_unit_assert.svh */
// Assertion macros shared by the lane allocator RTL.
`ifndef ROUND_ROBIN_LANE_ALLOCATOR_UNIT_ASSERT_SVH
`define ROUND_ROBIN_LANE_ALLOCATOR_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define RRLA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rrla: invariant violated");

// Same-cycle implication.
`define RRLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrla: implication violated");

// Next-cycle implication.
`define RRLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrla: next-cycle check violated");

`endif

/* rtl/core/rrla_pkg.sv */
`default_nettype none

package rrla_pkg;

    // Lane status codes
    localparam logic [1:0] ST_FREE      = 2'd0;
    localparam logic [1:0] ST_ACQUIRED  = 2'd1;
    localparam logic [1:0] ST_SUBMITTED = 2'd2;

    // Command codes
    localparam logic [1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [1:0] CMD_BIND    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_FIND    = 2'd3;

    // Command transaction payload
    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  lane;
        logic [63:0] fence_value;
    } cmd_t;

    // Result transaction payload
    typedef struct packed {
        logic [2:0] lane_out;
        logic       found;
        logic       error;
        logic [3:0] active;
        logic [2:0] last_grant;
        logic       last_grant_valid;
    } res_t;

    // Per-cell strobes from the controller
    typedef struct packed {
        logic inject;
        logic bind_we;
        logic rel_we;
        logic grant_we;
    } cell_ctl_t;

    // Signals broadcast to every cell of the ring
    typedef struct packed {
        logic        tok_shift;
        logic        tok_keep;
        logic        find_mode;
        logic [63:0] fence;
    } ring_bus_t;

endpackage

`default_nettype wire

/* rtl/core/rrla_stream_if.sv */
`default_nettype none

// Valid/ready channel carrying one payload per transaction.
interface rrla_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/round_robin_lane_allocator_unit.sv */
// Bind and release: the command is latched, then checked and applied in the
//   apply state. Acquire and find: a token walks the ring of lane cells one
//   cell per cycle until a lane matches or every cell has been visited.
// Either way the result is registered once the output is free. One command in
//   flight; the next is taken once the result is registered, even while it waits.
// Reset (async, active low): all lanes Free, no grant, no pending result.
`default_nettype none
`include "round_robin_lane_allocator_unit_assert.svh"

module round_robin_lane_allocator_unit
    import rrla_pkg::*;
#(
    parameter int LANES = 8
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rrla_stream_if.sink   cmd,
    rrla_stream_if.source res
);

    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int ACT_W = $clog2(LANES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LANES - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0] gp_reg, gp_next;
    logic             gpv_reg, gpv_next;
    logic [ACT_W-1:0] act_reg, act_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;

    cell_ctl_t        ctl [LANES];
    ring_bus_t        bus;
    logic [LANES-1:0] tok;
    logic [LANES-1:0] cell_hit;
    logic [1:0]       cell_status [LANES];

    logic             accept;
    logic             out_free;
    logic             new_is_scan;
    logic [IDX_W-1:0] rr_start;
    logic [IDX_W-1:0] inj_idx;
    logic             lane_ok;
    logic [IDX_W-1:0] lane_idx;
    logic [1:0]       sel_status;
    logic             hit_any;
    logic             scan_end;
    logic             emit;
    logic             r_found;
    logic             r_err;
    logic [2:0]       r_lane;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !res_valid_reg || res.ready;

    // Round-robin start just after the last grant
    assign rr_start = (!gpv_reg || (gp_reg == LAST_IDX)) ? '0 : gp_reg + 1'b1;
    assign new_is_scan = (cmd.payload.command == CMD_ACQUIRE)
                      || (cmd.payload.command == CMD_FIND);
    assign inj_idx = (cmd.payload.command == CMD_ACQUIRE) ? rr_start : '0;

    // Addressed lane checks for bind and release
    assign lane_ok    = (32'(cmd_reg.lane) < LANES);
    assign lane_idx   = IDX_W'(cmd_reg.lane);
    assign sel_status = lane_ok ? cell_status[lane_idx] : ST_FREE;

    assign hit_any  = |cell_hit;
    assign scan_end = hit_any || (step_reg == LAST_IDX);

    // Controller
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        step_next  = step_reg;
        gp_next    = gp_reg;
        gpv_next   = gpv_reg;
        act_next   = act_reg;
        emit       = 1'b0;
        r_found    = 1'b0;
        r_err      = 1'b0;
        r_lane     = 3'd0;
        for (int i = 0; i < LANES; i++)
        begin
            ctl[i] = '0;
        end
        bus.tok_shift = 1'b0;
        bus.tok_keep  = 1'b0;
        bus.find_mode = (cmd_reg.command == CMD_FIND);
        bus.fence     = cmd_reg.fence_value;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd.payload;
                    if (new_is_scan)
                    begin
                        for (int i = 0; i < LANES; i++)
                        begin
                            ctl[i].inject = (IDX_W'(i) == inj_idx);
                        end
                        pos_next   = inj_idx;
                        step_next  = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_APPLY;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        r_found    = hit_any;
                        r_lane     = hit_any ? 3'(pos_reg) : 3'd0;
                        state_next = S_IDLE;
                        if (hit_any && (cmd_reg.command == CMD_ACQUIRE))
                        begin
                            for (int i = 0; i < LANES; i++)
                            begin
                                ctl[i].grant_we = (IDX_W'(i) == pos_reg);
                            end
                            gp_next  = pos_reg;
                            gpv_next = 1'b1;
                            act_next = act_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        bus.tok_keep = 1'b1;
                    end
                end
                else
                begin
                    bus.tok_shift = 1'b1;
                    pos_next      = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
                    step_next     = step_reg + 1'b1;
                end
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (cmd_reg.command == CMD_BIND)
                    begin
                        r_err = !(lane_ok && (sel_status == ST_ACQUIRED));
                        for (int i = 0; i < LANES; i++)
                        begin
                            ctl[i].bind_we = !r_err && (IDX_W'(i) == lane_idx);
                        end
                    end
                    else
                    begin
                        r_err = !(lane_ok && (sel_status == ST_SUBMITTED));
                        for (int i = 0; i < LANES; i++)
                        begin
                            ctl[i].rel_we = !r_err && (IDX_W'(i) == lane_idx);
                        end
                        if (!r_err)
                        begin
                            act_next = act_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res.ready;
        if (emit)
        begin
            res_next.lane_out         = r_lane;
            res_next.found            = r_found;
            res_next.error            = r_err;
            res_next.active           = 4'(act_next);
            res_next.last_grant       = 3'(gp_next);
            res_next.last_grant_valid = gpv_next;
            res_valid_next            = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            step_reg      <= '0;
            gp_reg        <= '0;
            gpv_reg       <= 1'b0;
            act_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            step_reg      <= step_next;
            gp_reg        <= gp_next;
            gpv_reg       <= gpv_next;
            act_reg       <= act_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    assign res.valid   = res_valid_reg;
    assign res.payload = res_reg;

    // Ring of lane cells; the last cell feeds the first
    for (genvar i = 0; i < LANES; i++)
    begin : g_cell
        rrla_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl[i]),
            .bus      (bus),
            .tok_prev (tok[(i + LANES - 1) % LANES]),
            .tok      (tok[i]),
            .hit      (cell_hit[i]),
            .status   (cell_status[i])
        );
    end

    // Checks
    `RRLA_ASSERT_ALWAYS(a_tok_onehot, clk, rst_n, $onehot0(tok))
    `RRLA_ASSERT_IMPLY(a_tok_at_pos, clk, rst_n, state_reg == S_SCAN, tok == (LANES'(1) << pos_reg))
    `RRLA_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_reg != S_IDLE)
    `RRLA_ASSERT_ALWAYS(a_act_range, clk, rst_n, act_reg <= LANES)

endmodule

`default_nettype wire

/* rtl/core/rrla_cell.sv */
`default_nettype none

// One lane: status, fence and the scan token slot of the ring.
module rrla_cell
    import rrla_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire ring_bus_t bus,
    input  wire logic      tok_prev,
    output logic           tok,
    output logic           hit,
    output logic [1:0]     status
);

    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [63:0] fence_reg;
    logic        tok_reg;
    logic        tok_next;
    logic        match;

    // Status update; controller raises at most one strobe
    always_comb
    begin
        status_next = status_reg;
        if (ctl.bind_we)
        begin
            status_next = ST_SUBMITTED;
        end
        else if (ctl.rel_we)
        begin
            status_next = ST_FREE;
        end
        else if (ctl.grant_we)
        begin
            status_next = ST_ACQUIRED;
        end
    end

    // Token: injected, shifted in from the neighbor, held, or dropped
    assign tok_next = ctl.inject | (bus.tok_shift & tok_prev) | (bus.tok_keep & tok_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_FREE;
            tok_reg    <= 1'b0;
        end
        else
        begin
            status_reg <= status_next;
            tok_reg    <= tok_next;
        end
    end

    // Fence is only looked at while Submitted, which needs a bind first
    always_ff @(posedge clk)
    begin
        if (ctl.bind_we)
        begin
            fence_reg <= bus.fence;
        end
    end

    // Local test at the token position
    assign match = bus.find_mode ? ((status_reg == ST_SUBMITTED) && (fence_reg == bus.fence))
                                 : (status_reg == ST_FREE);

    assign hit    = tok_reg & match;
    assign tok    = tok_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

/* dv/tb_round_robin_lane_allocator_unit.sv */
`timescale 1ns / 1ps

module tb_round_robin_lane_allocator_unit;
    import rrla_pkg::*;

    localparam int LANES = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES = 2 * LANES + 4;

    logic clk = 1'b0;
    logic rst_n;

    rrla_stream_if #(.payload_t(cmd_t)) cmd_if ();
    rrla_stream_if #(.payload_t(res_t)) res_if ();

    round_robin_lane_allocator_unit #(
        .LANES(LANES)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    // Lane table mirror, advanced once per accepted command transaction
    logic [1:0]  lane_state [LANES];
    logic [63:0] lane_fence [LANES];
    logic [2:0]  grant_ptr;
    bit          grant_seen;

    res_t pending_results [$];
    int   error_count = 0;
    int   idle_cycles = 0;
    bit   src_idle_en = 1'b0;
    bit   snk_idle_en = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the lane table and return the result it produces
    function automatic res_t apply_lane_command(cmd_t c);
        res_t r;
        int   start;
        int   idx;
        int   busy;
        int   i;
        r = '0;
        case (c.command)
            CMD_ACQUIRE:
            begin
                start = grant_seen ? (int'(grant_ptr) + 1) % LANES : 0;
                for (i = 0; i < LANES; i++)
                begin
                    idx = (start + i) % LANES;
                    if (!r.found && lane_state[idx] == ST_FREE)
                    begin
                        lane_state[idx] = ST_ACQUIRED;
                        grant_ptr = idx[2:0];
                        grant_seen = 1'b1;
                        r.lane_out = idx[2:0];
                        r.found = 1'b1;
                    end
                end
            end
            CMD_BIND:
            begin
                if (int'(c.lane) >= LANES || lane_state[c.lane] != ST_ACQUIRED)
                    r.error = 1'b1;
                else
                begin
                    lane_state[c.lane] = ST_SUBMITTED;
                    lane_fence[c.lane] = c.fence_value;
                end
            end
            CMD_RELEASE:
            begin
                if (int'(c.lane) >= LANES || lane_state[c.lane] != ST_SUBMITTED)
                    r.error = 1'b1;
                else
                begin
                    lane_state[c.lane] = ST_FREE;
                    lane_fence[c.lane] = '0;
                end
            end
            default:
            begin
                // lowest-indexed submitted lane with a matching fence wins
                for (i = 0; i < LANES; i++)
                begin
                    if (!r.found && lane_state[i] == ST_SUBMITTED
                        && lane_fence[i] == c.fence_value)
                    begin
                        r.lane_out = i[2:0];
                        r.found = 1'b1;
                    end
                end
            end
        endcase
        busy = 0;
        for (i = 0; i < LANES; i++)
            if (lane_state[i] != ST_FREE)
                busy++;
        r.active = busy[3:0];
        r.last_grant = grant_ptr;
        r.last_grant_valid = grant_seen;
        return r;
    endfunction

    // Mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int idle_len(bit enable);
        int r;
        if (!enable)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic cmd_t make_cmd(logic [1:0] op, logic [2:0] lane, logic [63:0] fence);
        cmd_t c;
        c.command = op;
        c.lane = lane;
        c.fence_value = fence;
        return c;
    endfunction

    // Random lane currently in the given state, or -1 if none
    function automatic int pick_lane_in_state(logic [1:0] st);
        int hits [$];
        int i;
        for (i = 0; i < LANES; i++)
            if (lane_state[i] == st)
                hits.push_back(i);
        if (hits.size() == 0)
            return -1;
        return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    // Fences drawn from a small pool often, so that duplicates and hits occur
    function automatic logic [63:0] pick_fence();
        int r;
        int l;
        r = $urandom_range(0, 9);
        l = pick_lane_in_state(ST_SUBMITTED);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r == 2 && l >= 0)
            return lane_fence[l];
        else if (r < 5)
            return 64'($urandom_range(0, 3));
        return {$urandom, $urandom};
    endfunction

    // Mostly legal lane operations; a share of wrong-state and random requests
    function automatic cmd_t random_lane_command();
        int   r;
        int   l;
        cmd_t c;
        r = $urandom_range(0, 99);
        c = make_cmd(CMD_ACQUIRE, 3'($urandom_range(0, 7)), pick_fence());
        if (r < 30)
            c.command = CMD_ACQUIRE;
        else if (r < 55)
        begin
            c.command = CMD_BIND;
            l = pick_lane_in_state(ST_ACQUIRED);
            if (l >= 0 && $urandom_range(0, 9) != 0)
                c.lane = l[2:0];
        end
        else if (r < 75)
        begin
            c.command = CMD_RELEASE;
            l = pick_lane_in_state(ST_SUBMITTED);
            if (l >= 0 && $urandom_range(0, 9) != 0)
                c.lane = l[2:0];
        end
        else
        begin
            c.command = CMD_FIND;
            l = pick_lane_in_state(ST_SUBMITTED);
            if (l >= 0 && $urandom_range(0, 9) < 6)
                c.fence_value = lane_fence[l];
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("[chk] %0t %s: got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Send one command transaction; valid stays high into the next call
    task automatic send_cmd(cmd_t c);
        int gap;
        gap = idle_len(src_idle_en);
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.payload <= c;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        pending_results.push_back(apply_lane_command(c));
    endtask

    // Drop valid so the last command is not taken again, then drain
    task automatic wait_results_drained();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_errors();
        send_cmd(make_cmd(CMD_FIND, 3'd0, 64'd0));
        send_cmd(make_cmd(CMD_BIND, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        send_cmd(make_cmd(CMD_RELEASE, 3'd7, 64'd0));
        send_cmd(make_cmd(CMD_ACQUIRE, 3'd0, 64'd0));
    endtask

    // Fill every lane, then ask once more with all lanes busy
    task automatic test_acquire_wraparound();
        repeat (LANES) send_cmd(make_cmd(CMD_ACQUIRE, 3'd7, 64'd0));
    endtask

    task automatic test_fence_match();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        send_cmd(make_cmd(CMD_BIND, 3'd0, '1));
        send_cmd(make_cmd(CMD_BIND, 3'd1, '0));
        send_cmd(make_cmd(CMD_FIND, 3'd5, '1));
        send_cmd(make_cmd(CMD_FIND, 3'd0, '0));
        send_cmd(make_cmd(CMD_BIND, 3'd2, '1));
        send_cmd(make_cmd(CMD_FIND, 3'd0, '1));
        send_cmd(make_cmd(CMD_BIND, 3'd1, 64'h1234));
        send_cmd(make_cmd(CMD_RELEASE, 3'd3, '0));
        send_cmd(make_cmd(CMD_RELEASE, 3'd0, '1));
        send_cmd(make_cmd(CMD_FIND, 3'd0, '1));
        send_cmd(make_cmd(CMD_RELEASE, 3'd0, '0));
        send_cmd(make_cmd(CMD_ACQUIRE, 3'd0, '0));
    endtask

    task automatic test_random_traffic(int count, bit src_gaps, bit snk_gaps);
        src_idle_en = src_gaps;
        snk_idle_en = snk_gaps;
        repeat (count) send_cmd(random_lane_command());
    endtask

    // Result side: random backpressure
    initial
    begin
        int n;
        res_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            n = idle_len(snk_idle_en);
            if (n > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", res_if.payload, 0);
            else
            begin
                want = pending_results.pop_front();
                if (res_if.payload.lane_out !== want.lane_out)
                    report_mismatch("lane_out", res_if.payload.lane_out, want.lane_out);
                if (res_if.payload.found !== want.found)
                    report_mismatch("found", res_if.payload.found, want.found);
                if (res_if.payload.error !== want.error)
                    report_mismatch("error", res_if.payload.error, want.error);
                if (res_if.payload.active !== want.active)
                    report_mismatch("active", res_if.payload.active, want.active);
                if (res_if.payload.last_grant !== want.last_grant)
                    report_mismatch("last_grant", res_if.payload.last_grant,
                                    want.last_grant);
                if (res_if.payload.last_grant_valid !== want.last_grant_valid)
                    report_mismatch("last_grant_valid", res_if.payload.last_grant_valid,
                                    want.last_grant_valid);
            end
        end
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge clk)
    begin
        if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1)
            || (res_if.valid === 1'b1 && res_if.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[chk] watchdog expired, %0d results outstanding",
                     pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < LANES; i++)
        begin
            lane_state[i] = ST_FREE;
            lane_fence[i] = '0;
        end
        grant_ptr = '0;
        grant_seen = 1'b0;
        rst_n <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.payload <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_errors();
        test_acquire_wraparound();
        test_fence_match();
        test_random_traffic(160, 1'b0, 1'b0);
        test_random_traffic(460, 1'b1, 1'b1);
        // hold the sender until the block has delivered everything
        wait_results_drained();
        test_random_traffic(150, 1'b0, 1'b1);
        test_random_traffic(150, 1'b1, 1'b0);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
